// ===== design/smbh_pkg.sv =====
// Shared constants, types and control codes of the stereo mixer with high-pass biquad.
package smbh_pkg;

  localparam int CHANNELS       = 4;
  localparam int LEVEL_W        = 4;
  localparam int LEVEL_MAX      = 15;
  localparam int VOL_W          = 3;
  localparam int VOL_MAX        = 8;
  localparam int SAMPLE_FRAC    = 16;
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_W         = 32;
  localparam int SAMPLE_W       = 32;
  localparam int ACC_W          = 64;
  localparam int MASK_W         = 8;
  localparam int VOLREG_W       = 8;

  localparam int SUM_W   = $clog2(CHANNELS * LEVEL_MAX + 1);
  localparam int MIX_MAX = CHANNELS * LEVEL_MAX * VOL_MAX;
  localparam int MIX_W   = $clog2(MIX_MAX + 1);
  localparam int X_W     = MIX_W + SAMPLE_FRAC;
  localparam int D_W     = X_W + 2;
  localparam int Q_W     = ACC_W - COEF_FRAC_BITS;

  localparam logic [X_W-1:0] X_MAX = X_W'(MIX_MAX) << SAMPLE_FRAC;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]    ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]    ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]    RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic signed [COEF_W-1:0] B0_RST = COEF_W'(1) << COEF_FRAC_BITS;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2 = 3'd5;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_RND
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

endpackage

// ===== design/smbh_mac.sv =====
// Shared 32x32 signed multiplier with a saturating 64-bit accumulator.
module smbh_mac (
  input  logic                                   clk,
  input  smbh_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [smbh_pkg::COEF_W-1:0]     op_a,
  input  logic signed [smbh_pkg::COEF_W-1:0]     op_b,
  output logic signed [smbh_pkg::ACC_W-1:0]      acc
);

  logic signed [smbh_pkg::ACC_W-1:0] prod_full;
  logic signed [smbh_pkg::ACC_W-1:0] prod_r;
  logic signed [smbh_pkg::ACC_W-1:0] acc_r;
  logic signed [smbh_pkg::ACC_W:0]   wide_sum;
  logic signed [smbh_pkg::ACC_W-1:0] sat_sum;

  assign prod_full = op_a * op_b;

  always_comb begin
    case (ctrl.acc_op)
      smbh_pkg::ACC_SUB: wide_sum = {acc_r[smbh_pkg::ACC_W-1], acc_r}
                                  - {prod_r[smbh_pkg::ACC_W-1], prod_r};
      smbh_pkg::ACC_RND: wide_sum = {acc_r[smbh_pkg::ACC_W-1], acc_r}
                                  + {1'b0, smbh_pkg::RND_HALF};
      default:           wide_sum = {acc_r[smbh_pkg::ACC_W-1], acc_r};
    endcase
    if (wide_sum[smbh_pkg::ACC_W] != wide_sum[smbh_pkg::ACC_W-1]) begin
      sat_sum = wide_sum[smbh_pkg::ACC_W] ? smbh_pkg::ACC_MIN : smbh_pkg::ACC_MAX;
    end else begin
      sat_sum = wide_sum[smbh_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_full;
    end
    case (ctrl.acc_op)
      smbh_pkg::ACC_LOAD: acc_r <= prod_r;
      smbh_pkg::ACC_SUB:  acc_r <= sat_sum;
      smbh_pkg::ACC_RND:  acc_r <= sat_sum;
      default:            acc_r <= acc_r;
    endcase
  end

  assign acc = acc_r;

endmodule

// ===== design/stereo_mixer_biquad_highpass.sv =====
// Top level of the stereo mixer with per-side high-pass biquad and its sequencer.
// The block mixes four 4-bit channel levels into a left and a right sample and,
// when the filter is enabled, runs each side through a direct-form-I high-pass
// biquad. From acceptance, in_stall stays high through the mix step, the filter
// steps and store of each side (skipped in bypass) and the result step, so a new
// beat is taken only once the previous one is through, later if the previous
// result is still held by out_stall. The filter runs on the single shared 32x32
// multiplier and its saturating accumulator, which compute three products per
// side, right side first, plus a rounding step and a history update. A finished
// result waits in the output register while the next beat is taken in.
module stereo_mixer_biquad_highpass (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [smbh_pkg::LEVEL_W-1:0]              in_level_square_one,
  input  logic [smbh_pkg::LEVEL_W-1:0]              in_level_square_two,
  input  logic [smbh_pkg::LEVEL_W-1:0]              in_level_wave,
  input  logic [smbh_pkg::LEVEL_W-1:0]              in_level_noise,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [smbh_pkg::SAMPLE_W-1:0]      out_left_sample,
  output logic signed [smbh_pkg::SAMPLE_W-1:0]      out_right_sample,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [smbh_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [smbh_pkg::COEF_W-1:0]               cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_FILT,
    ST_STORE,
    ST_DONE
  } state_t;

  localparam logic SIDE_R = 1'b0;
  localparam logic SIDE_L = 1'b1;
  localparam logic [2:0] STEP_LAST = 3'd4;

  state_t state_r;
  logic [2:0] step_r;
  logic side_r;

  logic [smbh_pkg::MASK_W-1:0]      pan_r;
  logic [smbh_pkg::VOLREG_W-1:0]    vol_r;
  logic                             hpf_en_r;
  logic signed [smbh_pkg::COEF_W-1:0] b0_r;
  logic signed [smbh_pkg::COEF_W-1:0] a1_r;
  logic signed [smbh_pkg::COEF_W-1:0] a2_r;

  logic [smbh_pkg::LEVEL_W-1:0] lvl_r [smbh_pkg::CHANNELS];
  logic [smbh_pkg::X_W-1:0]     x_r   [2];
  logic [smbh_pkg::X_W-1:0]     xh0_r [2];
  logic [smbh_pkg::X_W-1:0]     xh1_r [2];
  logic signed [smbh_pkg::SAMPLE_W-1:0] yh0_r [2];
  logic signed [smbh_pkg::SAMPLE_W-1:0] yh1_r [2];
  logic signed [smbh_pkg::SAMPLE_W-1:0] res_r [2];

  logic out_valid_r;
  logic signed [smbh_pkg::SAMPLE_W-1:0] out_left_r;
  logic signed [smbh_pkg::SAMPLE_W-1:0] out_right_r;

  logic in_take;
  logic out_take;

  logic [smbh_pkg::SUM_W-1:0] sum_rt;
  logic [smbh_pkg::SUM_W-1:0] sum_lt;
  logic [smbh_pkg::VOL_W:0]   volp_rt;
  logic [smbh_pkg::VOL_W:0]   volp_lt;
  logic [smbh_pkg::X_W-1:0]   mix_x [2];

  logic signed [smbh_pkg::D_W-1:0]    d_val;
  smbh_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [smbh_pkg::COEF_W-1:0] mac_a;
  logic signed [smbh_pkg::COEF_W-1:0] mac_b;
  logic signed [smbh_pkg::ACC_W-1:0]  mac_acc;
  logic signed [smbh_pkg::Q_W-1:0]    acc_q;
  logic signed [smbh_pkg::SAMPLE_W-1:0] y_val;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

  always_comb begin
    sum_rt = '0;
    sum_lt = '0;
    for (int i = 0; i < smbh_pkg::CHANNELS; i++) begin
      if (pan_r[i]) begin
        sum_rt = sum_rt + smbh_pkg::SUM_W'(lvl_r[i]);
      end
      if (pan_r[i + smbh_pkg::CHANNELS]) begin
        sum_lt = sum_lt + smbh_pkg::SUM_W'(lvl_r[i]);
      end
    end
    volp_rt = {1'b0, vol_r[smbh_pkg::VOL_W-1:0]} + 1'b1;
    volp_lt = {1'b0, vol_r[smbh_pkg::VOL_W+3:4]} + 1'b1;
    mix_x[SIDE_R] = {smbh_pkg::MIX_W'(sum_rt * volp_rt), {smbh_pkg::SAMPLE_FRAC{1'b0}}};
    mix_x[SIDE_L] = {smbh_pkg::MIX_W'(sum_lt * volp_lt), {smbh_pkg::SAMPLE_FRAC{1'b0}}};
  end

  assign d_val = $signed({2'b00, x_r[side_r]})
               - $signed({1'b0, xh0_r[side_r], 1'b0})
               + $signed({2'b00, xh1_r[side_r]});

  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = smbh_pkg::ACC_HOLD;
    mac_a = smbh_pkg::COEF_W'(d_val);
    mac_b = b0_r;
    if (state_r == ST_FILT) begin
      case (step_r)
        3'd0: begin
          mac_ctrl.mul_en = 1'b1;
        end
        3'd1: begin
          mac_ctrl.mul_en = 1'b1;
          mac_ctrl.acc_op = smbh_pkg::ACC_LOAD;
          mac_a = yh0_r[side_r];
          mac_b = a1_r;
        end
        3'd2: begin
          mac_ctrl.mul_en = 1'b1;
          mac_ctrl.acc_op = smbh_pkg::ACC_SUB;
          mac_a = yh1_r[side_r];
          mac_b = a2_r;
        end
        3'd3: begin
          mac_ctrl.acc_op = smbh_pkg::ACC_SUB;
        end
        3'd4: begin
          mac_ctrl.acc_op = smbh_pkg::ACC_RND;
        end
        default: begin
          mac_ctrl.acc_op = smbh_pkg::ACC_HOLD;
        end
      endcase
    end
  end

  smbh_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  always_comb begin
    acc_q = mac_acc[smbh_pkg::ACC_W-1:smbh_pkg::COEF_FRAC_BITS];
    if (acc_q > smbh_pkg::Q_W'(smbh_pkg::SMP_MAX)) begin
      y_val = smbh_pkg::SMP_MAX;
    end else if (acc_q < smbh_pkg::Q_W'(smbh_pkg::SMP_MIN)) begin
      y_val = smbh_pkg::SMP_MIN;
    end else begin
      y_val = acc_q[smbh_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      side_r      <= SIDE_R;
      out_valid_r <= 1'b0;
      pan_r       <= '0;
      vol_r       <= '0;
      hpf_en_r    <= 1'b1;
      b0_r        <= smbh_pkg::B0_RST;
      a1_r        <= '0;
      a2_r        <= '0;
      for (int s = 0; s < 2; s++) begin
        xh0_r[s] <= '0;
        xh1_r[s] <= '0;
        yh0_r[s] <= '0;
        yh1_r[s] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smbh_pkg::CFG_PAN_MASK:   pan_r    <= cfg_data[smbh_pkg::MASK_W-1:0];
          smbh_pkg::CFG_MASTER_VOL: vol_r    <= cfg_data[smbh_pkg::VOLREG_W-1:0];
          smbh_pkg::CFG_HPF_ENABLE: hpf_en_r <= cfg_data[0];
          smbh_pkg::CFG_COEF_B0:    b0_r     <= cfg_data;
          smbh_pkg::CFG_COEF_A1:    a1_r     <= cfg_data;
          smbh_pkg::CFG_COEF_A2:    a2_r     <= cfg_data;
          default: ;
        endcase
      end

      if (out_take && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            lvl_r[0] <= in_level_square_one;
            lvl_r[1] <= in_level_square_two;
            lvl_r[2] <= in_level_wave;
            lvl_r[3] <= in_level_noise;
            state_r  <= ST_MIX;
          end
        end
        ST_MIX: begin
          x_r[SIDE_R] <= mix_x[SIDE_R];
          x_r[SIDE_L] <= mix_x[SIDE_L];
          side_r      <= SIDE_R;
          step_r      <= '0;
          if (hpf_en_r) begin
            state_r <= ST_FILT;
          end else begin
            res_r[SIDE_R] <= smbh_pkg::SAMPLE_W'(mix_x[SIDE_R]);
            res_r[SIDE_L] <= smbh_pkg::SAMPLE_W'(mix_x[SIDE_L]);
            state_r       <= ST_DONE;
          end
        end
        ST_FILT: begin
          if (step_r == STEP_LAST) begin
            state_r <= ST_STORE;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_STORE: begin
          res_r[side_r] <= y_val;
          xh1_r[side_r] <= xh0_r[side_r];
          xh0_r[side_r] <= x_r[side_r];
          yh1_r[side_r] <= yh0_r[side_r];
          yh0_r[side_r] <= y_val;
          step_r        <= '0;
          if (side_r == SIDE_R) begin
            side_r  <= SIDE_L;
            state_r <= ST_FILT;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_left_r  <= res_r[SIDE_L];
            out_right_r <= res_r[SIDE_R];
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_take_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_MIX)
    else $error("Accepted beat did not start the mix step.");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILT |-> step_r <= STEP_LAST)
    else $error("Filter step counter ran past its last step.");

  a_left_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE && side_r == SIDE_L) |=> state_r == ST_DONE)
    else $error("Left side store was not followed by the result step.");

  a_hist_range: assert property (@(posedge clk) disable iff (!rst_n)
    xh0_r[SIDE_R] <= smbh_pkg::X_MAX && xh0_r[SIDE_L] <= smbh_pkg::X_MAX)
    else $error("Input history holds a value beyond full scale.");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("Result appeared without passing through the result step.");

endmodule

// ===== bench/stereo_mixer_biquad_highpass_tb.sv =====
// Testbench for the stereo mixer with high-pass biquad, checked against a predictor.
module stereo_mixer_biquad_highpass_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_BEATS = 1530;
  localparam logic [smbh_pkg::CFG_IDX_W-1:0] CFG_RSVD_A = 3'd6;
  localparam logic [smbh_pkg::CFG_IDX_W-1:0] CFG_RSVD_B = 3'd7;
  localparam logic signed [67:0] ROUND_HALF = 68'sd1 <<< (smbh_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [smbh_pkg::SAMPLE_W-1:0] PEAK_POS = 32'sh7FFF_FFFF;
  localparam logic signed [smbh_pkg::SAMPLE_W-1:0] PEAK_NEG = 32'sh8000_0000;
  localparam logic [31:0] UNITY_GAIN = 32'h1 << smbh_pkg::COEF_FRAC_BITS;

  typedef struct packed {
    logic signed [smbh_pkg::SAMPLE_W-1:0] left;
    logic signed [smbh_pkg::SAMPLE_W-1:0] right;
  } stereo_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [smbh_pkg::LEVEL_W-1:0] in_level_square_one;
  logic [smbh_pkg::LEVEL_W-1:0] in_level_square_two;
  logic [smbh_pkg::LEVEL_W-1:0] in_level_wave;
  logic [smbh_pkg::LEVEL_W-1:0] in_level_noise;
  logic out_valid;
  logic out_stall;
  logic signed [smbh_pkg::SAMPLE_W-1:0] out_left_sample;
  logic signed [smbh_pkg::SAMPLE_W-1:0] out_right_sample;
  logic cfg_valid;
  logic cfg_ready;
  logic [smbh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [smbh_pkg::COEF_W-1:0] cfg_data;

  logic [smbh_pkg::MASK_W-1:0] pan_route;
  logic [smbh_pkg::VOLREG_W-1:0] vol_reg;
  logic filter_on;
  logic signed [smbh_pkg::COEF_W-1:0] gain_b0;
  logic signed [smbh_pkg::COEF_W-1:0] fb_a1;
  logic signed [smbh_pkg::COEF_W-1:0] fb_a2;
  logic signed [smbh_pkg::SAMPLE_W-1:0] x_hist [2][2];
  logic signed [smbh_pkg::SAMPLE_W-1:0] y_hist [2][2];

  stereo_t expected_samples [$];
  int fault_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  stereo_mixer_biquad_highpass u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_level_square_one (in_level_square_one),
    .in_level_square_two (in_level_square_two),
    .in_level_wave       (in_level_wave),
    .in_level_noise      (in_level_noise),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_left_sample     (out_left_sample),
    .out_right_sample    (out_right_sample),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [67:0] clamp_acc(input logic signed [67:0] v);
    if (v[67:63] == {5{v[67]}}) return v;
    return v[67] ? -(68'sd1 <<< 63) : (68'sd1 <<< 63) - 68'sd1;
  endfunction

  function automatic logic signed [smbh_pkg::SAMPLE_W-1:0] run_filter(
    input int side,
    input logic signed [smbh_pkg::SAMPLE_W-1:0] x
  );
    logic signed [35:0] xa, xb, xc, d;
    logic signed [67:0] acc, term;
    logic signed [63:0] q;
    logic signed [smbh_pkg::SAMPLE_W-1:0] y;
    xa = 36'(x);
    xb = 36'(x_hist[side][0]);
    xc = 36'(x_hist[side][1]);
    d = xa - (xb <<< 1) + xc;
    term = 68'(d) * 68'(gain_b0);
    acc = clamp_acc(term);
    term = 68'(y_hist[side][0]) * 68'(fb_a1);
    acc = clamp_acc(acc - clamp_acc(term));
    term = 68'(y_hist[side][1]) * 68'(fb_a2);
    acc = clamp_acc(acc - clamp_acc(term));
    acc = clamp_acc(acc + ROUND_HALF);
    q = acc[63:0];
    q = q >>> smbh_pkg::COEF_FRAC_BITS;
    if (q[63:31] == {33{q[63]}}) begin
      y = q[31:0];
    end else begin
      y = q[63] ? PEAK_NEG : PEAK_POS;
    end
    x_hist[side][1] = x_hist[side][0];
    x_hist[side][0] = x;
    y_hist[side][1] = y_hist[side][0];
    y_hist[side][0] = y;
    return y;
  endfunction

  function automatic stereo_t mix_sample(input logic [smbh_pkg::LEVEL_W-1:0] l0, l1, l2, l3);
    logic [smbh_pkg::LEVEL_W-1:0] lv [smbh_pkg::CHANNELS];
    logic [7:0] sum_r, sum_l;
    logic signed [smbh_pkg::SAMPLE_W-1:0] raw_r, raw_l;
    stereo_t res;
    lv[0] = l0;
    lv[1] = l1;
    lv[2] = l2;
    lv[3] = l3;
    sum_r = '0;
    sum_l = '0;
    for (int i = 0; i < smbh_pkg::CHANNELS; i++) begin
      if (pan_route[i]) sum_r += 8'(lv[i]);
      if (pan_route[i + smbh_pkg::CHANNELS]) sum_l += 8'(lv[i]);
    end
    raw_r = (32'(sum_r) * (32'(vol_reg[2:0]) + 32'd1)) << smbh_pkg::SAMPLE_FRAC;
    raw_l = (32'(sum_l) * (32'(vol_reg[6:4]) + 32'd1)) << smbh_pkg::SAMPLE_FRAC;
    if (filter_on) begin
      res.right = run_filter(0, raw_r);
      res.left = run_filter(1, raw_l);
    end else begin
      res.right = raw_r;
      res.left = raw_l;
    end
    return res;
  endfunction

  function automatic void latch_register(input logic [smbh_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
    case (idx)
      smbh_pkg::CFG_PAN_MASK:   pan_route = data[smbh_pkg::MASK_W-1:0];
      smbh_pkg::CFG_MASTER_VOL: vol_reg = data[smbh_pkg::VOLREG_W-1:0];
      smbh_pkg::CFG_HPF_ENABLE: filter_on = data[0];
      smbh_pkg::CFG_COEF_B0:    gain_b0 = data;
      smbh_pkg::CFG_COEF_A1:    fb_a1 = data;
      smbh_pkg::CFG_COEF_A2:    fb_a2 = data;
      default: ;
    endcase
  endfunction

  task automatic cfg_write(input logic [smbh_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    latch_register(idx, data);
  endtask

  task automatic write_settings(input logic [31:0] pan, vol, en, b0, a1, a2, input bit junk);
    cfg_write(smbh_pkg::CFG_PAN_MASK, pan);
    cfg_write(smbh_pkg::CFG_MASTER_VOL, vol);
    cfg_write(smbh_pkg::CFG_HPF_ENABLE, en);
    cfg_write(smbh_pkg::CFG_COEF_B0, b0);
    cfg_write(smbh_pkg::CFG_COEF_A1, a1);
    cfg_write(smbh_pkg::CFG_COEF_A2, a2);
    if (junk) begin
      cfg_write(CFG_RSVD_A, $urandom() | 32'h1);
      cfg_write(CFG_RSVD_B, $urandom() | 32'h1);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_levels(input logic [smbh_pkg::LEVEL_W-1:0] l0, l1, l2, l3);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    expected_samples.push_back(mix_sample(l0, l1, l2, l3));
    in_valid <= 1'b1;
    in_level_square_one <= l0;
    in_level_square_two <= l1;
    in_level_wave <= l2;
    in_level_noise <= l3;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    stereo_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected beat: left %0d right %0d", out_left_sample, out_right_sample);
        end
      end else begin
        exp_s = expected_samples.pop_front();
        if (out_left_sample !== exp_s.left) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("left mismatch: expected %0d, got %0d", exp_s.left, out_left_sample);
          end
        end
        if (out_right_sample !== exp_s.right) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("right mismatch: expected %0d, got %0d", exp_s.right, out_right_sample);
          end
        end
      end
    end
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_reset_defaults;
    send_levels(4'd15, 4'd15, 4'd15, 4'd15);
    send_levels(4'd0, 4'd0, 4'd0, 4'd0);
    send_levels(4'd15, 4'd0, 4'd15, 4'd0);
  endtask

  task automatic test_step_response;
    wait_drained();
    write_settings(32'hFF, 32'h77, 32'h1, UNITY_GAIN, 32'h0, 32'h0, 1'b0);
    repeat (3) send_levels(4'd15, 4'd15, 4'd15, 4'd15);
    repeat (2) send_levels(4'd0, 4'd0, 4'd0, 4'd0);
  endtask

  task automatic test_bypass_mix;
    wait_drained();
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, UNITY_GAIN, 32'h0, 32'h0, 1'b1);
    send_levels(4'd15, 4'd15, 4'd15, 4'd15);
    send_levels(4'd15, 4'd0, 4'd0, 4'd0);
    send_levels(4'd0, 4'd15, 4'd0, 4'd0);
    send_levels(4'd0, 4'd0, 4'd15, 4'd0);
    send_levels(4'd0, 4'd0, 4'd0, 4'd15);
    send_levels(4'd0, 4'd0, 4'd0, 4'd0);
    wait_drained();
    write_settings(32'h0F, 32'h70, 32'h0, UNITY_GAIN, 32'h0, 32'h0, 1'b0);
    send_levels(4'd15, 4'd15, 4'd15, 4'd15);
    wait_drained();
    write_settings(32'hA5, 32'h25, 32'h0, UNITY_GAIN, 32'h0, 32'h0, 1'b0);
    send_levels(4'd1, 4'd2, 4'd4, 4'd8);
    wait_drained();
    write_settings(32'h5A, 32'h52, 32'h0, UNITY_GAIN, 32'h0, 32'h0, 1'b0);
    send_levels(4'd8, 4'd4, 4'd2, 4'd1);
  endtask

  task automatic test_saturation;
    wait_drained();
    write_settings(32'hFF, 32'h77, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    repeat (2) begin
      send_levels(4'd15, 4'd15, 4'd15, 4'd15);
      send_levels(4'd0, 4'd0, 4'd0, 4'd0);
    end
    wait_drained();
    write_settings(32'hFF, 32'h77, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    repeat (2) begin
      send_levels(4'd15, 4'd15, 4'd15, 4'd15);
      send_levels(4'd0, 4'd0, 4'd0, 4'd0);
    end
  endtask

  task automatic randomize_settings;
    longint one, a2, a1, b0;
    logic [31:0] r;
    logic [31:0] en;
    one = longint'(UNITY_GAIN);
    r = $urandom();
    en = {r[31:1], ($urandom_range(3) != 0)};
    case ($urandom_range(3))
      0, 1: begin
        a2 = $urandom_range(one / 2, one * 98 / 100);
        a1 = -(one + a2) + $urandom_range(one / 1000, one / 2);
        b0 = (one - a1 + a2) / 4;
      end
      2: begin
        b0 = $urandom_range(0, 2 * one);
        a1 = 0;
        a2 = 0;
      end
      default: begin
        b0 = $urandom();
        a1 = $urandom();
        a2 = $urandom();
      end
    endcase
    write_settings($urandom(), $urandom(), en, b0[31:0], a1[31:0], a2[31:0],
                   $urandom_range(7) == 0);
  endtask

  task automatic test_random_traffic;
    int remaining, seg, choice;
    logic [smbh_pkg::LEVEL_W-1:0] lv [smbh_pkg::CHANNELS];
    for (int i = 0; i < smbh_pkg::CHANNELS; i++) lv[i] = '0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 35 : 0;
      remaining = RANDOM_BEATS / 3;
      while (remaining > 0) begin
        seg = $urandom_range(20, 90);
        if (seg > remaining) seg = remaining;
        remaining -= seg;
        wait_drained();
        randomize_settings();
        repeat (seg) begin
          choice = $urandom_range(9);
          if (choice == 3) begin
            for (int i = 0; i < smbh_pkg::CHANNELS; i++) begin
              lv[i] = smbh_pkg::LEVEL_W'(smbh_pkg::LEVEL_MAX);
            end
          end else if (choice == 4) begin
            for (int i = 0; i < smbh_pkg::CHANNELS; i++) lv[i] = '0;
          end else if (choice > 4) begin
            for (int i = 0; i < smbh_pkg::CHANNELS; i++) begin
              lv[i] = smbh_pkg::LEVEL_W'($urandom_range(smbh_pkg::LEVEL_MAX));
            end
          end
          send_levels(lv[0], lv[1], lv[2], lv[3]);
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_level_square_one <= '0;
    in_level_square_two <= '0;
    in_level_wave <= '0;
    in_level_noise <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pan_route = '0;
    vol_reg = '0;
    filter_on = 1'b1;
    gain_b0 = UNITY_GAIN;
    fb_a1 = '0;
    fb_a2 = '0;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < 2; k++) begin
        x_hist[s][k] = '0;
        y_hist[s][k] = '0;
      end
    end
    send_idle_pct = 35;
    recv_idle_pct = 47;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_step_response();
    test_bypass_mix();
    test_saturation();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    if (fault_count == 0 && expected_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
